FILE: design/ott_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ott_pkg: shared types and constants of the one-shot timeout table
// Field widths, opcodes, result kinds, the divide-by-tick reciprocal and the
// words that pass between the front end, the back end and the result queue.
// ----------------------------------------------------------------------------
package ott_pkg;

   localparam int SLOTS       = 16;
   localparam int TICK_MS     = 10;
   localparam int MAX_RESULTS = 16;

   localparam int OP_W       = 2;
   localparam int DUR_W      = 32;
   localparam int SID_W      = 8;
   localparam int KIND_W     = 2;
   localparam int RSP_SLOT_W = 4;
   localparam int COUNT_W    = 29;

   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int SENT_W = $clog2(MAX_RESULTS + 1);

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   // Opcodes of an input word
   localparam logic [OP_W-1:0] OP_TICK       = 2'd0;
   localparam logic [OP_W-1:0] OP_REGISTER   = 2'd1;
   localparam logic [OP_W-1:0] OP_UNREGISTER = 2'd2;
   localparam logic [OP_W-1:0] OP_UNUSED     = 2'd3;

   // Kinds of a result word
   localparam logic [KIND_W-1:0] KIND_REGISTER   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_UNREGISTER = 2'd1;
   localparam logic [KIND_W-1:0] KIND_EXPIRY     = 2'd2;

   // floor(d / TICK_MS) == (d * RECIP) >> RECIP_SHIFT for every 32-bit d
   localparam int RECIP_SHIFT = DUR_W + $clog2(TICK_MS);
   localparam int RECIP_W     = DUR_W + 1;
   localparam int PROD_W      = RECIP_SHIFT + DUR_W;
   localparam logic [63:0] RECIP_FULL =
      ((64'd1 << RECIP_SHIFT) + 64'(TICK_MS) - 64'd1) / 64'(TICK_MS);
   localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

   // Queue between front and back
   localparam int WQ_DEPTH = 2;
   localparam int WQ_AW    = $clog2(WQ_DEPTH);
   // Result queue
   localparam int RQ_DEPTH = 2;
   localparam int RQ_AW    = $clog2(RQ_DEPTH);

   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [COUNT_W-1:0] count;
      logic               notify;
      logic [SID_W-1:0]   sid;
   } work_type;

   typedef struct packed {
      logic     valid;
      work_type work;
   } work_head_type;

   typedef struct packed {
      logic [KIND_W-1:0]     kind;
      logic [RSP_SLOT_W-1:0] slot;
      logic                  ok;
      logic                  last;
   } result_type;

endpackage

FILE: design/ott_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ott_front: request intake
// Accepts request words, drops unused opcodes, turns the duration into a
// tick count through a registered reciprocal multiply and queues the work.
// ----------------------------------------------------------------------------
module ott_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_push,
   output logic                         req_full,
   input  logic [ott_pkg::OP_W-1:0]     req_op,
   input  logic [ott_pkg::DUR_W-1:0]    req_duration_ms,
   input  logic                         req_notify,
   input  logic [ott_pkg::SID_W-1:0]    req_slot_id,
   output ott_pkg::work_head_type       head,
   input  logic                         head_pop
);

   logic                          s1_valid_ff, s1_valid_in;
   logic [ott_pkg::OP_W-1:0]      s1_op_ff;
   logic                          s1_notify_ff;
   logic [ott_pkg::SID_W-1:0]     s1_sid_ff;
   logic [ott_pkg::PROD_W-1:0]    s1_prod_ff;

   ott_pkg::work_type             wq_mem_ff [ott_pkg::WQ_DEPTH];
   logic [ott_pkg::WQ_AW-1:0]     wq_rd_ff, wq_wr_ff;
   logic [ott_pkg::WQ_AW:0]       wq_cnt_ff, wq_cnt_in;

   logic                          accept, wq_full, s1_move;
   logic [ott_pkg::DUR_W-1:0]     quot;
   ott_pkg::work_type             s1_work;

   assign wq_full  = (wq_cnt_ff == (ott_pkg::WQ_AW+1)'(ott_pkg::WQ_DEPTH));
   assign s1_move  = s1_valid_ff && !wq_full;
   assign req_full = s1_valid_ff && wq_full;
   assign accept   = req_push && !req_full;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (s1_move) s1_valid_in = 1'b0;
      if (accept && req_op != ott_pkg::OP_UNUSED) s1_valid_in = 1'b1;
   end

   // saturate the quotient into the count width
   assign quot = s1_prod_ff[ott_pkg::RECIP_SHIFT +: ott_pkg::DUR_W];
   always_comb begin
      s1_work.op     = s1_op_ff;
      s1_work.notify = s1_notify_ff;
      s1_work.sid    = s1_sid_ff;
      if (|quot[ott_pkg::DUR_W-1:ott_pkg::COUNT_W]) begin
         s1_work.count = ott_pkg::COUNT_MAX;
      end else begin
         s1_work.count = quot[ott_pkg::COUNT_W-1:0];
      end
   end

   always_comb begin
      wq_cnt_in = wq_cnt_ff;
      if (s1_move && !head_pop) wq_cnt_in = wq_cnt_ff + (ott_pkg::WQ_AW+1)'(1);
      if (!s1_move && head_pop) wq_cnt_in = wq_cnt_ff - (ott_pkg::WQ_AW+1)'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         wq_rd_ff    <= '0;
         wq_wr_ff    <= '0;
         wq_cnt_ff   <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         wq_cnt_ff   <= wq_cnt_in;
         if (s1_move)  wq_wr_ff <= wq_wr_ff + ott_pkg::WQ_AW'(1);
         if (head_pop) wq_rd_ff <= wq_rd_ff + ott_pkg::WQ_AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff     <= req_op;
         s1_notify_ff <= req_notify;
         s1_sid_ff    <= req_slot_id;
         s1_prod_ff   <= ott_pkg::PROD_W'(req_duration_ms) *
                         ott_pkg::PROD_W'(ott_pkg::RECIP);
      end
      if (s1_move) wq_mem_ff[wq_wr_ff] <= s1_work;
   end

   assign head.valid = (wq_cnt_ff != '0);
   assign head.work  = wq_mem_ff[wq_rd_ff];

endmodule

FILE: design/ott_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ott_back: slot table and sequencer
// Holds the countdown slots, serves register and unregister words in one step and
// walks all slots on a tick, one per cycle unless the output stalls, emitting expiries.
// ----------------------------------------------------------------------------
module ott_back (
   input  logic                    clock,
   input  logic                    reset,
   input  ott_pkg::work_head_type  head,
   output logic                    head_pop,
   output logic                    out_valid,
   output ott_pkg::result_type     out_word,
   input  logic                    out_full
);

   typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_FLUSH} state_type;

   state_type                      state_ff;
   logic [ott_pkg::COUNT_W-1:0]    count_ff [ott_pkg::SLOTS];
   logic [ott_pkg::SLOTS-1:0]      busy_ff;
   logic [ott_pkg::SLOTS-1:0]      armed_ff;
   logic [ott_pkg::SLOT_W-1:0]     idx_ff;
   logic                           pend_valid_ff;
   logic [ott_pkg::SLOT_W-1:0]     pend_slot_ff;
   logic [ott_pkg::SENT_W-1:0]     sent_ff;
   logic                           out_valid_ff;
   ott_pkg::result_type            out_word_ff;

   logic                           can_emit;
   logic                           emit;
   logic                           free_found;
   logic [ott_pkg::SLOT_W-1:0]     free_idx;
   logic [ott_pkg::COUNT_W-1:0]    walk_dec;
   logic [ott_pkg::SLOT_W-1:0]     sid_idx;

   assign can_emit = !out_valid_ff || !out_full;
   assign head_pop = (state_ff == ST_IDLE) && head.valid && can_emit;
   assign walk_dec = count_ff[idx_ff] - ott_pkg::COUNT_W'(1);
   assign sid_idx  = head.work.sid[ott_pkg::SLOT_W-1:0];

   // a new result word enters the output register this cycle
   always_comb begin
      case (state_ff)
         ST_IDLE: begin
            emit = head_pop &&
                   (head.work.op inside {ott_pkg::OP_REGISTER, ott_pkg::OP_UNREGISTER});
         end
         ST_WALK: begin
            emit = can_emit && busy_ff[idx_ff] && (walk_dec == '0) &&
                   armed_ff[idx_ff] && pend_valid_ff &&
                   (sent_ff < ott_pkg::SENT_W'(ott_pkg::MAX_RESULTS));
         end
         ST_FLUSH: begin
            emit = can_emit && pend_valid_ff;
         end
         default: emit = 1'b0;
      endcase
   end

   // lowest free slot
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = ott_pkg::SLOTS - 1; i >= 0; i--) begin
         if (!busy_ff[i]) begin
            free_found = 1'b1;
            free_idx   = ott_pkg::SLOT_W'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         busy_ff       <= '0;
         armed_ff      <= '0;
         idx_ff        <= '0;
         pend_valid_ff <= 1'b0;
         sent_ff       <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         out_valid_ff <= emit || (out_valid_ff && out_full);
         case (state_ff)
            ST_IDLE: begin
               if (head_pop) begin
                  case (head.work.op)
                     ott_pkg::OP_REGISTER: begin
                        out_word_ff.kind      <= ott_pkg::KIND_REGISTER;
                        out_word_ff.last      <= 1'b1;
                        if (free_found) begin
                           count_ff[free_idx] <= head.work.count;
                           busy_ff[free_idx]  <= (head.work.count != '0);
                           armed_ff[free_idx] <= head.work.notify;
                           out_word_ff.slot   <= ott_pkg::RSP_SLOT_W'(free_idx);
                           out_word_ff.ok     <= 1'b1;
                        end else begin
                           out_word_ff.slot   <= '0;
                           out_word_ff.ok     <= 1'b0;
                        end
                     end
                     ott_pkg::OP_UNREGISTER: begin
                        out_word_ff.kind <= ott_pkg::KIND_UNREGISTER;
                        out_word_ff.last <= 1'b1;
                        if (head.work.sid < ott_pkg::SID_W'(ott_pkg::SLOTS)) begin
                           busy_ff[sid_idx]  <= 1'b0;
                           armed_ff[sid_idx] <= 1'b0;
                           out_word_ff.slot  <= ott_pkg::RSP_SLOT_W'(head.work.sid);
                           out_word_ff.ok    <= 1'b1;
                        end else begin
                           out_word_ff.slot  <= '0;
                           out_word_ff.ok    <= 1'b0;
                        end
                     end
                     ott_pkg::OP_TICK: begin
                        state_ff      <= ST_WALK;
                        idx_ff        <= '0;
                        pend_valid_ff <= 1'b0;
                        sent_ff       <= '0;
                     end
                     default: ;
                  endcase
               end
            end
            ST_WALK: begin
               if (can_emit) begin
                  if (busy_ff[idx_ff]) begin
                     count_ff[idx_ff] <= walk_dec;
                     if (walk_dec == '0) begin
                        busy_ff[idx_ff] <= 1'b0;
                        if (armed_ff[idx_ff]) begin
                           armed_ff[idx_ff] <= 1'b0;
                           if (sent_ff < ott_pkg::SENT_W'(ott_pkg::MAX_RESULTS)) begin
                              // hold this expiry until we know whether it is the final one
                              if (pend_valid_ff) begin
                                 out_word_ff.kind <= ott_pkg::KIND_EXPIRY;
                                 out_word_ff.slot <= ott_pkg::RSP_SLOT_W'(pend_slot_ff);
                                 out_word_ff.ok   <= 1'b1;
                                 out_word_ff.last <= 1'b0;
                              end
                              pend_valid_ff <= 1'b1;
                              pend_slot_ff  <= idx_ff;
                              sent_ff       <= sent_ff + ott_pkg::SENT_W'(1);
                           end
                        end
                     end
                  end
                  if (idx_ff == ott_pkg::SLOT_W'(ott_pkg::SLOTS - 1)) begin
                     state_ff <= ST_FLUSH;
                  end else begin
                     idx_ff <= idx_ff + ott_pkg::SLOT_W'(1);
                  end
               end
            end
            ST_FLUSH: begin
               if (can_emit) begin
                  if (pend_valid_ff) begin
                     out_word_ff.kind <= ott_pkg::KIND_EXPIRY;
                     out_word_ff.slot <= ott_pkg::RSP_SLOT_W'(pend_slot_ff);
                     out_word_ff.ok   <= 1'b1;
                     out_word_ff.last <= 1'b1;
                  end
                  pend_valid_ff <= 1'b0;
                  state_ff      <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign out_valid = out_valid_ff;
   assign out_word  = out_word_ff;

endmodule

FILE: design/ott_rsp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ott_rsp_queue: result queue
// Small register queue that buffers result words toward the rsp_ side.
// ----------------------------------------------------------------------------
module ott_rsp_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  ott_pkg::result_type  push_word,
   output logic                 full,
   input  logic                 pop,
   output logic                 empty,
   output ott_pkg::result_type  head_word
);

   ott_pkg::result_type        mem_ff [ott_pkg::RQ_DEPTH];
   logic [ott_pkg::RQ_AW-1:0]  rd_ff, wr_ff;
   logic [ott_pkg::RQ_AW:0]    cnt_ff, cnt_in;
   logic                       do_push, do_pop;

   assign full    = (cnt_ff == (ott_pkg::RQ_AW+1)'(ott_pkg::RQ_DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      cnt_in = cnt_ff;
      if (do_push && !do_pop) cnt_in = cnt_ff + (ott_pkg::RQ_AW+1)'(1);
      if (!do_push && do_pop) cnt_in = cnt_ff - (ott_pkg::RQ_AW+1)'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff  <= '0;
         wr_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (do_push) wr_ff <= wr_ff + ott_pkg::RQ_AW'(1);
         if (do_pop)  rd_ff <= rd_ff + ott_pkg::RQ_AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ff] <= push_word;
   end

   assign head_word = mem_ff[rd_ff];

endmodule

FILE: design/oneshot_timeout_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oneshot_timeout_table: table of one-shot millisecond timeouts
// Register claims the lowest free slot, unregister frees one, a tick counts
// every busy slot down and reports each armed slot that reaches zero.
// ----------------------------------------------------------------------------
//  channel  ports                                         handshake
//  request  req_op, req_duration_ms, req_notify,          req_push / req_full
//           req_slot_id
//  result   rsp_kind, rsp_slot, rsp_ok, rsp_last          rsp_empty / rsp_pop
//
//  Register and unregister words pass through the reciprocal stage, the work
//  queue, the sequencer output register and the result queue.
//  A tick holds the sequencer for a dispatch step, a walk of one slot per cycle
//  unless stalled, and a flush; the sequencer handles one word at a time.
//  Reset clears all slots to free at once, no clearing pass.
//  A full result queue stalls the sequencer, which in turn fills the work
//  queue and raises req_full.
// ----------------------------------------------------------------------------
module oneshot_timeout_table (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   output logic                              req_full,
   input  logic [ott_pkg::OP_W-1:0]          req_op,
   input  logic [ott_pkg::DUR_W-1:0]         req_duration_ms,
   input  logic                              req_notify,
   input  logic [ott_pkg::SID_W-1:0]         req_slot_id,
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output logic [ott_pkg::KIND_W-1:0]        rsp_kind,
   output logic [ott_pkg::RSP_SLOT_W-1:0]    rsp_slot,
   output logic                              rsp_ok,
   output logic                              rsp_last
);

   ott_pkg::work_head_type  head;
   logic                    head_pop;
   logic                    res_valid;
   ott_pkg::result_type     res_word;
   logic                    res_full;
   ott_pkg::result_type     rsp_word;

   ott_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_op          (req_op),
      .req_duration_ms (req_duration_ms),
      .req_notify      (req_notify),
      .req_slot_id     (req_slot_id),
      .head            (head),
      .head_pop        (head_pop)
   );

   ott_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .head_pop  (head_pop),
      .out_valid (res_valid),
      .out_word  (res_word),
      .out_full  (res_full)
   );

   ott_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_word (res_word),
      .full      (res_full),
      .pop       (rsp_pop),
      .empty     (rsp_empty),
      .head_word (rsp_word)
   );

   assign rsp_kind = rsp_word.kind;
   assign rsp_slot = rsp_word.slot;
   assign rsp_ok   = rsp_word.ok;
   assign rsp_last = rsp_word.last;

`ifndef ASSERT_OFF
   // replies to register and unregister are always the final word of their item
   a_reply_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_kind != ott_pkg::KIND_EXPIRY) |-> rsp_last)
      else $error("reply word without last");

   // expiry words always report success
   a_expiry_ok: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_kind == ott_pkg::KIND_EXPIRY) |-> rsp_ok)
      else $error("expiry word with ok low");

   // a failed reply carries slot zero
   a_fail_slot: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_ok) |-> (rsp_slot == '0))
      else $error("failed reply with nonzero slot");

   // the sequencer never pops the work queue while it is empty
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      head_pop |-> head.valid)
      else $error("work queue popped while empty");
`endif

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the one-shot timeout table
// Drives register, unregister, tick and unused words through the request
// queue. A scoreboard keeps its own copy of the slot counts and notify flags and
// predicts each result word. Every popped word is checked against the oldest
// prediction. Random idling on both sides, plus one long result stall that
// backs the block up until it refuses requests.
// ----------------------------------------------------------------------------
import ott_pkg::*;

class timeout_scoreboard;
   logic [COUNT_W-1:0] ticks_left [SLOTS];
   logic               armed [SLOTS];
   result_type         due_q [$];
   int                 errors;

   function new();
      for (int i = 0; i < SLOTS; i++) begin
         ticks_left[i] = '0;
         armed[i] = 1'b0;
      end
      errors = 0;
   endfunction

   function result_type mk(logic [KIND_W-1:0] kind, int slot, logic ok, logic last);
      result_type r;
      r.kind = kind;
      r.slot = RSP_SLOT_W'(slot);
      r.ok = ok;
      r.last = last;
      return r;
   endfunction

   // Advance the table by one accepted request word and queue its results.
   function void note_word(logic [OP_W-1:0] op, logic [DUR_W-1:0] dur, logic nfy,
                           logic [SID_W-1:0] sid);
      int          free_slot;
      logic [63:0] cnt;
      result_type  fired [$];
      case (op)
         OP_REGISTER: begin
            free_slot = -1;
            for (int i = SLOTS - 1; i >= 0; i--)
               if (ticks_left[i] == '0) free_slot = i;
            if (free_slot < 0) begin
               due_q.push_back(mk(KIND_REGISTER, 0, 1'b0, 1'b1));
            end else begin
               cnt = 64'(dur) / 64'(TICK_MS);
               if (cnt > 64'(COUNT_MAX)) cnt = 64'(COUNT_MAX);
               ticks_left[free_slot] = cnt[COUNT_W-1:0];
               armed[free_slot] = nfy;
               due_q.push_back(mk(KIND_REGISTER, free_slot, 1'b1, 1'b1));
            end
         end
         OP_UNREGISTER: begin
            if (sid < SLOTS) begin
               ticks_left[sid] = '0;
               armed[sid] = 1'b0;
               due_q.push_back(mk(KIND_UNREGISTER, int'(sid), 1'b1, 1'b1));
            end else begin
               due_q.push_back(mk(KIND_UNREGISTER, 0, 1'b0, 1'b1));
            end
         end
         OP_TICK: begin
            for (int i = 0; i < SLOTS; i++) begin
               if (ticks_left[i] != '0) begin
                  ticks_left[i] = ticks_left[i] - 1'b1;
                  if (ticks_left[i] == '0 && armed[i]) begin
                     armed[i] = 1'b0;
                     // slots past the result cap still disarm, unreported
                     if (fired.size() < MAX_RESULTS)
                        fired.push_back(mk(KIND_EXPIRY, i, 1'b1, 1'b0));
                  end
               end
            end
            if (fired.size() > 0) fired[fired.size() - 1].last = 1'b1;
            foreach (fired[k]) due_q.push_back(fired[k]);
         end
         default: ;
      endcase
   endfunction

   function void report(string what, result_type want, result_type got);
      errors++;
      if (errors <= 10)
         $display("%0t: %s: want kind %0d slot %0d ok %0b last %0b, got %0d %0d %0b %0b",
                  $time, what, want.kind, want.slot, want.ok, want.last,
                  got.kind, got.slot, got.ok, got.last);
   endfunction

   function void check_word(logic [KIND_W-1:0] kind, logic [RSP_SLOT_W-1:0] slot,
                            logic ok, logic last);
      result_type got;
      result_type want;
      got.kind = kind;
      got.slot = slot;
      got.ok = ok;
      got.last = last;
      if (due_q.size() == 0) begin
         want = '0;
         report("unexpected result word", want, got);
      end else begin
         want = due_q.pop_front();
         if (got.kind !== want.kind || got.slot !== want.slot ||
             got.ok !== want.ok || got.last !== want.last)
            report("result word mismatch", want, got);
      end
   endfunction

   function int pending();
      return due_q.size();
   endfunction
endclass

module tb;
   localparam int RANDOM_WORDS = 434;
   localparam int HOLD_CYCLES  = 300;
   localparam int CYCLE_LIMIT  = 600000;

   logic                  clock;
   logic                  reset;
   logic                  req_push;
   logic                  req_full;
   logic [OP_W-1:0]       req_op;
   logic [DUR_W-1:0]      req_duration_ms;
   logic                  req_notify;
   logic [SID_W-1:0]      req_slot_id;
   logic                  rsp_empty;
   logic                  rsp_pop;
   logic [KIND_W-1:0]     rsp_kind;
   logic [RSP_SLOT_W-1:0] rsp_slot;
   logic                  rsp_ok;
   logic                  rsp_last;

   timeout_scoreboard sb;
   int send_idle_pct;
   int recv_idle_pct;
   bit hold_pending;
   int hold_left;
   int cycles;

   oneshot_timeout_table dut (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_op          (req_op),
      .req_duration_ms (req_duration_ms),
      .req_notify      (req_notify),
      .req_slot_id     (req_slot_id),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_kind        (rsp_kind),
      .rsp_slot        (rsp_slot),
      .rsp_ok          (rsp_ok),
      .rsp_last        (rsp_last)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("oneshot_timeout_table regression: fail");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty)
         sb.check_word(rsp_kind, rsp_slot, rsp_ok, rsp_last);
   end

   // Result side: random pops, or a long hold-off when one is requested.
   initial begin
      rsp_pop <= 1'b0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_pending) begin
            hold_left = HOLD_CYCLES;
            hold_pending = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= ($urandom_range(99, 0) >= recv_idle_pct);
         end
      end
   end

   // Offer one word, idling first at random; returns at the falling edge
   // after the word is taken.
   task automatic send_word(logic [OP_W-1:0] op, logic [DUR_W-1:0] dur, logic nfy,
                            logic [SID_W-1:0] sid);
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push        <= 1'b1;
      req_op          <= op;
      req_duration_ms <= dur;
      req_notify      <= nfy;
      req_slot_id     <= sid;
      @(posedge clock);
      while (req_full) @(posedge clock);
      sb.note_word(op, dur, nfy, sid);
      @(negedge clock);
   endtask

   initial begin
      int               sent;
      int               pick;
      logic [OP_W-1:0]  op;
      logic [DUR_W-1:0] dur;
      logic             nfy;
      logic [SID_W-1:0] sid;

      sb = new();
      cycles = 0;
      hold_pending = 1'b0;
      send_idle_pct = 17;
      recv_idle_pct = 61;
      reset           <= 1'b1;
      req_push        <= 1'b0;
      req_op          <= OP_TICK;
      req_duration_ms <= '0;
      req_notify      <= 1'b0;
      req_slot_id     <= '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: ignored opcode, quiet tick, zero-tick durations reuse slot 0
      send_word(OP_UNUSED, 32'hFFFF_FFFF, 1'b1, 8'hFF);
      send_word(OP_TICK, '0, 1'b0, '0);
      send_word(OP_REGISTER, 32'd0, 1'b1, '0);
      send_word(OP_REGISTER, 32'd9, 1'b1, '0);
      // fill every slot: one- and two-tick timers, one huge one, one without notify
      for (int i = 0; i < SLOTS; i++) begin
         if (i == 6)
            send_word(OP_REGISTER, 32'hFFFF_FFFF, 1'b1, '0);
         else
            send_word(OP_REGISTER, DUR_W'(10 + i), (i != 9), '0);
      end
      send_word(OP_REGISTER, 32'd50, 1'b1, '0);
      send_word(OP_UNREGISTER, '0, 1'b0, 8'd255);
      send_word(OP_UNREGISTER, '0, 1'b0, 8'(SLOTS));
      send_word(OP_UNREGISTER, '0, 1'b0, 8'(SLOTS - 1));
      send_word(OP_TICK, '0, 1'b0, '0);
      send_word(OP_TICK, '0, 1'b0, '0);

      // Random: mostly short timers so slots expire, a few very long ones
      sent = 0;
      while (sent < RANDOM_WORDS) begin
         if (sent == RANDOM_WORDS / 3) begin
            send_idle_pct = 61;
            recv_idle_pct = 17;
         end else if (sent == 2 * RANDOM_WORDS / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end else if (sent == 2 * RANDOM_WORDS / 3 + 10) begin
            hold_pending = 1'b1;
         end
         pick = $urandom_range(99, 0);
         if (pick < 40)      op = OP_TICK;
         else if (pick < 75) op = OP_REGISTER;
         else if (pick < 95) op = OP_UNREGISTER;
         else                op = OP_UNUSED;
         if ($urandom_range(19, 0) == 0) dur = $urandom();
         else                            dur = DUR_W'($urandom_range(80, 0));
         nfy = 1'($urandom_range(1, 0));
         if ($urandom_range(4, 0) == 0) sid = 8'($urandom_range(255, 0));
         else                           sid = 8'($urandom_range(SLOTS - 1, 0));
         send_word(op, dur, nfy, sid);
         sent++;
      end
      req_push <= 1'b0;

      // Drain, then give the sequencer time to show any stray word.
      recv_idle_pct = 0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SLOTS + 12) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("oneshot_timeout_table regression: pass");
      else
         $display("oneshot_timeout_table regression: fail");
      $finish;
   end
endmodule
